### hw/rtl/lva_pkg.sv
// Shared types, field widths and codes of the voice allocator.
`timescale 1ns / 1ps
package lva_pkg;

    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int MASK_W     = 8;
    localparam int GAP_W      = 20;
    localparam int VOUT_W     = 3;
    localparam int IDX_W_MAX  = 5;
    localparam int REQ_W      = 2;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ON   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_OFF  = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PLUCK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GLIDE   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEGATO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd2;

    typedef struct packed {
        logic              legato_on;
        logic [VEL_W-1:0]  velocity_limit;
        logic [GAP_W-1:0]  gap_limit;
    } t_cfg;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic [MASK_W-1:0] active_mask;
    } t_item;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [VOUT_W-1:0] voice_index;
        logic              stolen;
        logic [NOTE_W-1:0] out_note;
        logic [MASK_W-1:0] released_mask;
    } t_result;

    // A voice rings only if it has a bit in the mask.
    function automatic logic rings(logic [MASK_W-1:0] mask, logic [IDX_W_MAX-1:0] v);
        return (v < IDX_W_MAX'(MASK_W)) && mask[v[2:0]];
    endfunction

endpackage

### hw/rtl/lva_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/lva_alloc.sv
// Allocation sequencer: scans the voice memories and updates voice state.
`timescale 1ns / 1ps
module lva_alloc #(
    parameter int VOICE_COUNT = 8,
    parameter int TIME_BITS   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lva_pkg::t_cfg   i_cfg,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  lva_pkg::t_item  i_req,
    input  logic            i_slot_free,
    output logic            o_res_valid,
    output lva_pkg::t_result o_res
);
    import lva_pkg::*;

    localparam int VIDX_W = $clog2(VOICE_COUNT);
    localparam int CMP_W  = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
    localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICE_COUNT - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} t_state;

    t_state                 r_state;
    t_item                  r_item;
    logic                   r_glide;
    logic                   r_issue;
    logic [VIDX_W-1:0]      r_rd_idx;
    logic                   r_ret_vld;
    logic [VIDX_W-1:0]      r_ret_idx;
    logic                   r_found;
    logic [VIDX_W-1:0]      r_free_idx;
    logic [TIME_BITS-1:0]   r_best;
    logic [VIDX_W-1:0]      r_best_idx;
    logic [MASK_W-1:0]      r_rel;
    logic [VOICE_COUNT-1:0] r_valid;
    logic [VOICE_COUNT-1:0] r_twritten;
    logic                   r_recent_vld;
    logic [VIDX_W-1:0]      r_recent;
    logic [TIME_BITS-1:0]   r_last_on;
    logic [TIME_BITS-1:0]   r_count;

    logic                   w_accept;
    logic                   w_finish;
    logic [TIME_BITS-1:0]   w_gap;
    logic                   w_glide;
    logic [VIDX_W-1:0]      w_pick;
    logic [IDX_W_MAX-1:0]   w_pick5;
    logic [IDX_W_MAX-1:0]   w_ret5;
    logic [NOTE_W-1:0]      w_note_rd;
    logic [TIME_BITS-1:0]   w_time_rd;
    logic [TIME_BITS-1:0]   w_ret_time;
    logic                   w_wr_note;

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_finish    = (r_state == ST_FINISH) && i_slot_free;

    assign w_gap   = r_count - r_last_on;
    assign w_glide = i_cfg.legato_on && r_recent_vld
                     && rings(i_req.active_mask, IDX_W_MAX'(r_recent))
                     && (i_req.velocity < i_cfg.velocity_limit)
                     && (CMP_W'(w_gap) < CMP_W'(i_cfg.gap_limit));

    assign w_pick  = r_glide ? r_recent : (r_found ? r_free_idx : r_best_idx);
    assign w_pick5 = IDX_W_MAX'(w_pick);
    assign w_ret5  = IDX_W_MAX'(r_ret_idx);
    // Entries never plucked read as start time zero.
    assign w_ret_time = r_twritten[r_ret_idx] ? w_time_rd : '0;
    assign w_wr_note  = w_finish && (r_item.req_type == REQ_ON);

    lva_ram #(.WIDTH(NOTE_W), .DEPTH(VOICE_COUNT)) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_note),
        .i_waddr (w_pick),
        .i_wdata (r_item.note),
        .i_raddr (r_rd_idx),
        .o_rdata (w_note_rd)
    );

    lva_ram #(.WIDTH(TIME_BITS), .DEPTH(VOICE_COUNT)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_note && !r_glide),
        .i_waddr (w_pick),
        .i_wdata (r_count),
        .i_raddr (r_rd_idx),
        .o_rdata (w_time_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_issue      <= 1'b0;
            r_ret_vld    <= 1'b0;
            r_valid      <= '0;
            r_twritten   <= '0;
            r_recent_vld <= 1'b0;
            r_recent     <= '0;
            r_last_on    <= '0;
            r_count      <= '0;
        end else begin
            r_ret_vld <= (r_state == ST_SCAN) && r_issue;
            r_ret_idx <= r_rd_idx;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_item   <= i_req;
                        r_glide  <= w_glide;
                        r_rd_idx <= '0;
                        r_found  <= 1'b0;
                        r_rel    <= '0;
                        if ((i_req.req_type == REQ_ON && !w_glide)
                            || i_req.req_type == REQ_OFF) begin
                            r_issue <= 1'b1;
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN: begin
                    // Issue one read a cycle, process each entry as it returns.
                    if (r_issue) begin
                        if (r_rd_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + VIDX_W'(1);
                        end
                    end
                    if (r_ret_vld) begin
                        if (r_item.req_type == REQ_ON) begin
                            if (!r_found && !r_valid[r_ret_idx]
                                && !rings(r_item.active_mask, w_ret5)) begin
                                r_found    <= 1'b1;
                                r_free_idx <= r_ret_idx;
                            end
                            if (r_ret_idx == '0 || w_ret_time < r_best) begin
                                r_best     <= w_ret_time;
                                r_best_idx <= r_ret_idx;
                            end
                        end else if (r_valid[r_ret_idx] && w_note_rd == r_item.note) begin
                            r_valid[r_ret_idx] <= 1'b0;
                            if (w_ret5 < IDX_W_MAX'(MASK_W)) begin
                                r_rel[w_ret5[2:0]] <= 1'b1;
                            end
                        end
                        if (r_ret_idx == LAST_IDX) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (i_slot_free) begin
                        r_state <= ST_IDLE;
                        if (r_item.req_type == REQ_TICK) begin
                            if (r_count != '1) begin
                                r_count <= r_count + TIME_BITS'(1);
                            end
                        end else if (r_item.req_type == REQ_ON) begin
                            r_last_on       <= r_count;
                            r_valid[w_pick] <= 1'b1;
                            if (!r_glide) begin
                                r_twritten[w_pick] <= 1'b1;
                                r_recent_vld       <= 1'b1;
                                r_recent           <= w_pick;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_res_valid = w_finish;
        o_res       = '0;
        if (r_item.req_type == REQ_ON) begin
            o_res.action      = r_glide ? ACT_GLIDE : ACT_PLUCK;
            o_res.voice_index = w_pick5[VOUT_W-1:0];
            o_res.stolen      = !r_glide && !r_found;
            o_res.out_note    = r_item.note;
        end else if (r_item.req_type == REQ_OFF) begin
            o_res.action        = ACT_RELEASE;
            o_res.released_mask = r_rel;
        end
    end

    a_rel_only_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.action != ACT_RELEASE) |-> (o_res.released_mask == '0))
        else $error("released mask set on a non-release result");

    a_stolen_only_pluck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.stolen) |-> (o_res.action == ACT_PLUCK))
        else $error("stolen flag without a pluck");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count >= $past(r_count)))
        else $error("sample count went backward");

    a_return_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ret_vld |-> (r_state == ST_SCAN))
        else $error("memory return outside the scan");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_issue) |=> (r_state == ST_SCAN))
        else $error("scan ended before all reads were issued");
endmodule

### hw/rtl/legato_voice_allocator.sv
// Top level: stream ports, configuration registers and result register.
// A tick, glide or unused-type request goes from idle straight to the finish state; a pluck or
// note-off first runs the one-read-a-cycle voice scan over every voice. The result is
// loaded as it leaves the finish state, and no new request is taken until it is loaded;
// a held result stalls the sequencer.
// Reset (synchronous, active low) frees all voices and restores register defaults at once.
`timescale 1ns / 1ps
module legato_voice_allocator #(
    parameter int VOICE_COUNT = 8,
    parameter int TIME_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lva_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lva_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // note [6:0], velocity [13:7], active_mask [21:14], zero [23:22]
    input  logic [23:0]                        s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // voice_index [2:0], stolen [3], out_note [10:4], released_mask [18:11], zero [23:19]
    output logic [23:0]                        m_axis_tdata,
    // action [1:0]
    output logic [1:0]                         m_axis_tuser
);
    import lva_pkg::*;

    t_cfg        r_cfg;
    logic        r_m_valid;
    logic [23:0] r_m_tdata;
    logic [1:0]  r_m_tuser;
    t_item       w_item;
    t_result     w_res;
    logic        w_res_valid;
    logic        w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.legato_on      <= 1'b1;
            r_cfg.velocity_limit <= VEL_W'(100);
            r_cfg.gap_limit      <= GAP_W'(4800);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEGATO: r_cfg.legato_on      <= i_cfg_data[0];
                CFG_VEL:    r_cfg.velocity_limit <= i_cfg_data[VEL_W-1:0];
                CFG_GAP:    r_cfg.gap_limit      <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_item.req_type    = s_axis_tuser;
    assign w_item.note        = s_axis_tdata[6:0];
    assign w_item.velocity    = s_axis_tdata[13:7];
    assign w_item.active_mask = s_axis_tdata[21:14];

    assign w_slot_free = !r_m_valid || m_axis_tready;

    lva_alloc #(.VOICE_COUNT(VOICE_COUNT), .TIME_BITS(TIME_BITS)) u_alloc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_item),
        .i_slot_free (w_slot_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Hold the result until taken; load a new one as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_valid <= 1'b1;
            r_m_tuser <= w_res.action;
            r_m_tdata <= {5'd0, w_res.released_mask, w_res.out_note,
                          w_res.stolen, w_res.voice_index};
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;
endmodule

### dv/lva_checker.sv
// Checker for the voice allocator: predicts every result from the requests seen and compares.
`timescale 1ns / 1ps
module lva_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lva_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lva_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // note [6:0], velocity [13:7], active_mask [21:14], zero [23:22]
    input  logic [23:0]                    s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // voice_index [2:0], stolen [3], out_note [10:4], released_mask [18:11], zero [23:19]
    input  logic [23:0]                    m_axis_tdata,
    // action [1:0]
    input  logic [1:0]                     m_axis_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);
    import lva_pkg::*;

    localparam int VOICES = 8;

    logic              legato_on;
    logic [VEL_W-1:0]  vel_limit;
    logic [GAP_W-1:0]  gap_limit;
    logic              voice_busy  [VOICES];
    logic [NOTE_W-1:0] voice_note  [VOICES];
    logic [31:0]       voice_start [VOICES];
    logic              recent_ok;
    logic [2:0]        recent_voice;
    logic [31:0]       last_on_time;
    logic [31:0]       sample_cnt;
    t_result           voice_actions_q [$];

    task automatic allocate_voice(input t_item req, output t_result res);
        logic [31:0] gap;
        logic        glide;
        logic        found;
        logic [2:0]  pick;
        logic [31:0] oldest;
        res  = '0;
        pick = '0;
        case (req.req_type)
            REQ_TICK: begin
                if (sample_cnt != '1) begin
                    sample_cnt = sample_cnt + 32'd1;
                end
            end
            REQ_ON: begin
                gap   = sample_cnt - last_on_time;
                glide = legato_on && recent_ok && req.active_mask[recent_voice]
                        && (req.velocity < vel_limit) && (gap < 32'(gap_limit));
                last_on_time = sample_cnt;
                if (glide) begin
                    pick       = recent_voice;
                    res.action = ACT_GLIDE;
                end else begin
                    found = 1'b0;
                    for (int v = 0; v < VOICES; v++) begin
                        if (!found && !req.active_mask[v] && !voice_busy[v]) begin
                            pick  = 3'(v);
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        // steal the oldest; strict compare keeps the lowest index on a tie
                        oldest = voice_start[0];
                        for (int v = 1; v < VOICES; v++) begin
                            if (voice_start[v] < oldest) begin
                                oldest = voice_start[v];
                                pick   = 3'(v);
                            end
                        end
                        res.stolen = 1'b1;
                    end
                    voice_start[pick] = sample_cnt;
                    recent_ok         = 1'b1;
                    recent_voice      = pick;
                    res.action        = ACT_PLUCK;
                end
                voice_busy[pick] = 1'b1;
                voice_note[pick] = req.note;
                res.voice_index  = pick;
                res.out_note     = req.note;
            end
            REQ_OFF: begin
                // free every holder of the note; the recent voice stays recent
                for (int v = 0; v < VOICES; v++) begin
                    if (voice_busy[v] && voice_note[v] == req.note) begin
                        voice_busy[v]        = 1'b0;
                        res.released_mask[v] = 1'b1;
                    end
                end
                res.action = ACT_RELEASE;
            end
            default: begin
                res.action = ACT_NONE;
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_item   req;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            legato_on    = 1'b1;
            vel_limit    = 7'd100;
            gap_limit    = 20'd4800;
            recent_ok    = 1'b0;
            recent_voice = '0;
            last_on_time = '0;
            sample_cnt   = '0;
            o_fail_count = 0;
            for (int v = 0; v < VOICES; v++) begin
                voice_busy[v]  = 1'b0;
                voice_note[v]  = '0;
                voice_start[v] = '0;
            end
            voice_actions_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEGATO: legato_on = i_cfg_data[0];
                    CFG_VEL:    vel_limit = i_cfg_data[VEL_W-1:0];
                    CFG_GAP:    gap_limit = i_cfg_data[GAP_W-1:0];
                    default:    ;
                endcase
            end
            // compare before pushing: a result never belongs to a same-edge request
            if (m_axis_tvalid && m_axis_tready) begin
                got.action        = m_axis_tuser;
                got.voice_index   = m_axis_tdata[2:0];
                got.stolen        = m_axis_tdata[3];
                got.out_note      = m_axis_tdata[10:4];
                got.released_mask = m_axis_tdata[18:11];
                if (voice_actions_q.size() == 0) begin
                    $error("result with no request outstanding: action %0d", got.action);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = voice_actions_q.pop_front();
                    check_field("action", 32'(want.action), 32'(got.action));
                    check_field("voice_index", 32'(want.voice_index),
                                32'(got.voice_index));
                    check_field("stolen", 32'(want.stolen), 32'(got.stolen));
                    check_field("out_note", 32'(want.out_note), 32'(got.out_note));
                    check_field("released_mask", 32'(want.released_mask),
                                32'(got.released_mask));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.req_type    = s_axis_tuser;
                req.note        = s_axis_tdata[6:0];
                req.velocity    = s_axis_tdata[13:7];
                req.active_mask = s_axis_tdata[21:14];
                allocate_voice(req, want);
                voice_actions_q.push_back(want);
            end
        end
        o_pending = voice_actions_q.size();
    end

endmodule

### dv/tb_legato_voice_allocator.sv
// Testbench top for the voice allocator: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_legato_voice_allocator;
    import lva_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;
    localparam int               ITEMS_PHASE  = 125;
    localparam int               SETTLE_CYCLES = 16;
    localparam int               QUIET_LIMIT  = 2000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int                    fails;
    int                    pending;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    quiet_cycles   = 0;
    logic [VEL_W-1:0]      vel_now        = 7'd100;

    legato_voice_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lva_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fails),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // count cycles in which neither channel moves a request or a result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic t_item make_request(logic [REQ_W-1:0] kind, int note, int vel,
                                           logic [MASK_W-1:0] mask);
        t_item r;
        r.req_type    = kind;
        r.note        = NOTE_W'(note);
        r.velocity    = VEL_W'(vel);
        r.active_mask = mask;
        return r;
    endfunction

    // mostly a small pool of notes so that note-offs hit held voices
    function automatic t_item random_request();
        t_item r;
        int    pick;
        int    vel;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
            r.note = NOTE_W'($urandom_range(0, 127));
        end else begin
            r.note = NOTE_W'(60 + $urandom_range(0, 5));
        end
        if ($urandom_range(0, 4) < 2) begin
            vel = $urandom_range(0, 127);
        end else begin
            vel = $urandom_range(0, 3);
            vel = vel + int'(vel_now) - 2;
            if (vel < 0) vel = 0;
            if (vel > 127) vel = 127;
        end
        r.velocity = VEL_W'(vel);
        case ($urandom_range(0, 3))
            0:       r.active_mask = 8'h00;
            1:       r.active_mask = 8'hFF;
            default: r.active_mask = MASK_W'($urandom_range(0, 255));
        endcase
        if (pick < 35) begin
            r.req_type = REQ_TICK;
        end else if (pick < 70) begin
            r.req_type = REQ_ON;
        end else if (pick < 95) begin
            r.req_type = REQ_OFF;
        end else begin
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    // enter and leave at a falling edge
    task automatic send_request(input t_item r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.active_mask, r.velocity, r.note};
        s_axis_tuser  <= r.req_type;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic legato, input int vel, input int gap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LEGATO;
        i_cfg_data <= CFG_DATA_W'(legato);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_VEL;
        i_cfg_data <= CFG_DATA_W'(vel);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_GAP;
        i_cfg_data <= CFG_DATA_W'(gap);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        vel_now     = VEL_W'(vel);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // tick and unused type carry junk fields that must not leak into the result
        send_request(make_request(REQ_TICK, 127, 127, 8'hFF));
        send_request(make_request(REQ_UNUSED, 85, 42, 8'hA5));
        send_request(make_request(REQ_OFF, 127, 0, 8'h00));
        // two voices on one note, then one note-off frees both
        send_request(make_request(REQ_ON, 0, 127, 8'h00));
        send_request(make_request(REQ_ON, 0, 127, 8'h00));
        send_request(make_request(REQ_OFF, 0, 0, 8'h00));
        send_request(make_request(REQ_ON, 60, 10, 8'h01));
        send_request(make_request(REQ_ON, 62, 10, 8'h02));
        // glide onto a voice that was released but is still the recent one
        send_request(make_request(REQ_OFF, 62, 0, 8'h00));
        send_request(make_request(REQ_ON, 64, 99, 8'h02));
        send_request(make_request(REQ_ON, 65, 100, 8'h02));
        // every string ringing: steal, ties first, then by age
        send_request(make_request(REQ_ON, 1, 127, 8'hFF));
        for (int k = 0; k < 3; k++) begin
            send_request(make_request(REQ_TICK, 0, 0, 8'h00));
            send_request(make_request(REQ_ON, 2 + k, 127, 8'hFF));
        end
        send_request(make_request(REQ_ON, 127, 0, 8'hFF));
        send_request(make_request(REQ_OFF, 127, 127, 8'hFF));
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: apply_settings(1'b0, 127, 1048575);
                2: apply_settings(1'b1, 127, 1048575);
                3: apply_settings(1'b1, 0, 5);
                4: apply_settings(1'b1, 64, 0);
                5: apply_settings(1'b1, $urandom_range(1, 126), $urandom_range(1, 20));
                6: apply_settings(1'b1, 127, 3);
                7: apply_settings(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                                  $urandom_range(0, 1048575));
                default: ;
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (int k = 0; k < ITEMS_PHASE; k++) begin
                if (k == ITEMS_PHASE / 2) begin
                    // hold off the sender until every result is back
                    wait_idle();
                end
                send_request(random_request());
            end
            wait_idle();
        end

        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### legato_voice_allocator.f
hw/rtl/lva_pkg.sv
hw/rtl/lva_ram.sv
hw/rtl/lva_alloc.sv
hw/rtl/legato_voice_allocator.sv
dv/lva_checker.sv
dv/tb_legato_voice_allocator.sv
